/* hdl/periodic_task_slot_table_macros.svh */
// assertion helpers for the slot table; empty bodies for synthesis
`ifndef PERIODIC_TASK_SLOT_TABLE_MACROS_SVH
`define PERIODIC_TASK_SLOT_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot table check failed");

// next-cycle implication
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot table check failed");

`else

`define PTS_ASSERT_NOW(label, clk, rst, ante, cons)

`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/pts_pkg.sv */
`default_nettype none

package pts_pkg;

   localparam int HANDLE_W    = 8;
   localparam int PEND_W      = 8;
   localparam int SLOT_OUT_W  = 4;
   localparam int MAX_RESULTS = 16;
   localparam int N_W         = $clog2(MAX_RESULTS + 1);

   localparam logic [PEND_W-1:0] PEND_MAX = '1;

   typedef enum logic [1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_ADD      = 2'd1,
      FUNC_DELETE   = 2'd2,
      FUNC_DISPATCH = 2'd3
   } func_type;

   localparam logic KIND_ADD_ACK = 1'b0;
   localparam logic KIND_RUN     = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // what the slot update asks of the sweep
   typedef struct packed {
      logic write;
      logic emit;
      logic clear;
   } upd_ctl_type;

endpackage

`default_nettype wire

/* hdl/pts_ram.sv */
`default_nettype none

module pts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/pts_slot_upd.sv */
`default_nettype none

module pts_slot_upd import pts_pkg::*; #(
   parameter int TIME_BITS = 16
) (
   input  wire logic                 is_dispatch,
   input  wire logic                 occupied,
   input  wire logic [TIME_BITS-1:0] delay_left,
   input  wire logic [TIME_BITS-1:0] slot_period,
   input  wire logic [PEND_W-1:0]    pending,
   output logic      [TIME_BITS-1:0] delay_out,
   output logic      [PEND_W-1:0]    pending_out,
   output upd_ctl_type               ctl
);

   always_comb begin
      delay_out   = delay_left;
      pending_out = pending;
      ctl         = '0;
      if (is_dispatch) begin
         // free slots read as zero, so they never run
         ctl.emit    = occupied && (pending != '0);
         ctl.write   = ctl.emit;
         ctl.clear   = ctl.emit && (slot_period == '0);
         pending_out = pending - 1'b1;
      end else begin
         ctl.write = occupied;
         if (delay_left == '0) begin
            delay_out = slot_period;
            if (pending != PEND_MAX) begin
               pending_out = pending + 1'b1;
            end
         end else begin
            delay_out = delay_left - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/periodic_task_slot_table.sv */
// Periodic task slot table: a cooperative scheduler's task list in one RAM.
// Request channel (req_*): func selects tick, add, delete or dispatch; an item
// is taken while req_valid and req_ready are high, and req_ready is high
// only while the block is idle.
// Response channel (rsp_*): one add acknowledgement per add, one run per slot
// with pending runs on dispatch (at most 16 per dispatch), rsp_last marking
// the final response of a request. Tick and delete give no response.
// Timing: tick and dispatch sweep the slot RAM one slot per cycle and keep
// the block busy until the sweep ends; a dispatch with runs then flushes its
// held run, and a dispatch sweep pauses while it waits on rsp_ready. Delete
// completes in the cycle it is taken. Add scans the occupancy flags one slot
// per cycle until it finds a free slot or reaches the last one, and answers
// once the response register is free. Each dispatch run is held back until
// the next run, or the end of the sweep, shows whether it is the last.
// Reset clears every occupancy flag at once, so all slots are free in the
// first cycle after reset; RAM contents are left as they are.
// A stalled receiver holds the response register; the sweep pauses when a
// second run is ready and no register is free, and resumes without loss.
`default_nettype none

`include "periodic_task_slot_table_macros.svh"

module periodic_task_slot_table import pts_pkg::*; #(
   parameter int SLOT_COUNT = 16,
   parameter int TIME_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_task_handle,
   input  wire logic [15:0] req_first_delay,
   input  wire logic [15:0] req_run_period,
   input  wire logic [3:0]  req_slot_number,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic             rsp_status,
   output logic [3:0]       rsp_slot_index,
   output logic [7:0]       rsp_run_handle,
   output logic             rsp_last
);

   localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int ENTRY_W = HANDLE_W + 2 * TIME_BITS + PEND_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_SWEEP,
      S_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   func_type              func_ff, func_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic [TIME_BITS-1:0]  delay_ff, delay_in;
   logic [TIME_BITS-1:0]  period_ff, period_in;
   logic [CNT_W-1:0]      iss_ff, iss_in;
   logic                  p1_vld_ff, p1_vld_in;
   logic [SLOT_W-1:0]     p1_slot_ff, p1_slot_in;
   logic [N_W-1:0]        n_ff, n_in;
   logic                  hold_vld_ff, hold_vld_in;
   logic [SLOT_W-1:0]     hold_slot_ff, hold_slot_in;
   logic [HANDLE_W-1:0]   hold_handle_ff, hold_handle_in;
   logic [SLOT_COUNT-1:0] occ_ff, occ_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  ram_we;
   logic [SLOT_W-1:0]     ram_wa;
   logic [ENTRY_W-1:0]    ram_wd;
   logic                  ram_re;
   logic [SLOT_W-1:0]     ram_ra;
   logic [ENTRY_W-1:0]    ram_rd;

   logic [SLOT_W-1:0]     iss_idx;
   logic                  occ_p1;
   logic [HANDLE_W-1:0]   rd_handle;
   logic [TIME_BITS-1:0]  rd_delay;
   logic [TIME_BITS-1:0]  rd_period;
   logic [PEND_W-1:0]     rd_pend;
   logic [TIME_BITS-1:0]  upd_delay;
   logic [PEND_W-1:0]     upd_pend;
   upd_ctl_type           upd_ctl;
   logic                  is_dispatch;
   logic                  out_free;
   logic                  p1_act;
   logic                  stall;
   logic                  add_free;
   logic                  add_last;

   pts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // a free slot always reads as an all-zero entry
   assign occ_p1    = occ_ff[p1_slot_ff];
   assign rd_handle = occ_p1 ? ram_rd[ENTRY_W-1 -: HANDLE_W] : '0;
   assign rd_delay  = occ_p1 ? ram_rd[ENTRY_W-HANDLE_W-1 -: TIME_BITS] : '0;
   assign rd_period = occ_p1 ? ram_rd[PEND_W +: TIME_BITS] : '0;
   assign rd_pend   = occ_p1 ? ram_rd[PEND_W-1:0] : '0;

   assign is_dispatch = (func_ff == FUNC_DISPATCH);

   pts_slot_upd #(
      .TIME_BITS (TIME_BITS)
   ) u_upd (
      .is_dispatch (is_dispatch),
      .occupied    (occ_p1),
      .delay_left  (rd_delay),
      .slot_period (rd_period),
      .pending     (rd_pend),
      .delay_out   (upd_delay),
      .pending_out (upd_pend),
      .ctl         (upd_ctl)
   );

   assign iss_idx  = iss_ff[SLOT_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign p1_act   = p1_vld_ff && !(is_dispatch && (n_ff == N_W'(MAX_RESULTS)));
   assign stall    = p1_act && upd_ctl.emit && hold_vld_ff && !out_free;
   assign add_free = !occ_ff[iss_idx];
   assign add_last = (iss_ff == CNT_W'(SLOT_COUNT - 1));

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      handle_in      = handle_ff;
      delay_in       = delay_ff;
      period_in      = period_ff;
      iss_in         = iss_ff;
      p1_vld_in      = p1_vld_ff;
      p1_slot_in     = p1_slot_ff;
      n_in           = n_ff;
      hold_vld_in    = hold_vld_ff;
      hold_slot_in   = hold_slot_ff;
      hold_handle_in = hold_handle_ff;
      occ_in         = occ_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_wa         = p1_slot_ff;
      ram_wd         = {rd_handle, upd_delay, rd_period, upd_pend};
      ram_re         = 1'b0;
      ram_ra         = iss_idx;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = func_type'(req_func);
               handle_in = req_task_handle;
               delay_in  = TIME_BITS'(req_first_delay);
               period_in = TIME_BITS'(req_run_period);
               iss_in    = '0;
               n_in      = '0;
               case (func_type'(req_func))
                  FUNC_TICK, FUNC_DISPATCH: begin
                     state_in = S_SWEEP;
                  end
                  FUNC_ADD: begin
                     state_in = S_ADD;
                  end
                  FUNC_DELETE: begin
                     if (int'(req_slot_number) < SLOT_COUNT) begin
                        occ_in[SLOT_W'(req_slot_number)] = 1'b0;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_ADD: begin
            if ((handle_ff == '0) || (!add_free && add_last)) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_ADD_ACK;
                  rsp_status_in = STATUS_REJECT;
                  rsp_slot_in   = '0;
                  rsp_handle_in = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (add_free) begin
               if (out_free) begin
                  ram_we         = 1'b1;
                  ram_wa         = iss_idx;
                  ram_wd         = {handle_ff, delay_ff, period_ff, {PEND_W{1'b0}}};
                  occ_in[iss_idx] = 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_ADD_ACK;
                  rsp_status_in  = STATUS_OK;
                  rsp_slot_in    = SLOT_OUT_W'(iss_idx);
                  rsp_handle_in  = '0;
                  rsp_last_in    = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               iss_in = CNT_W'(iss_ff + 1'b1);
            end
         end

         S_SWEEP: begin
            if (!stall) begin
               if (p1_act && upd_ctl.write) begin
                  ram_we = 1'b1;
                  ram_wa = p1_slot_ff;
                  if (upd_ctl.clear) begin
                     occ_in[p1_slot_ff] = 1'b0;
                  end
               end
               // a run waits in the hold register until we know whether it is the last
               if (p1_act && upd_ctl.emit) begin
                  n_in = N_W'(n_ff + 1'b1);
                  if (hold_vld_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_RUN;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = SLOT_OUT_W'(hold_slot_ff);
                     rsp_handle_in = hold_handle_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_vld_in    = 1'b1;
                  hold_slot_in   = p1_slot_ff;
                  hold_handle_in = rd_handle;
               end
               if (iss_ff < CNT_W'(SLOT_COUNT)) begin
                  ram_re     = 1'b1;
                  ram_ra     = iss_idx;
                  p1_vld_in  = 1'b1;
                  p1_slot_in = iss_idx;
                  iss_in     = CNT_W'(iss_ff + 1'b1);
               end else begin
                  p1_vld_in = 1'b0;
                  if (!p1_vld_ff) begin
                     state_in = hold_vld_ff ? S_FLUSH : S_IDLE;
                  end
               end
            end
         end

         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_RUN;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = SLOT_OUT_W'(hold_slot_ff);
               rsp_handle_in = hold_handle_ff;
               rsp_last_in   = 1'b1;
               hold_vld_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_ff       <= '0;
         n_ff         <= '0;
         p1_vld_ff    <= 1'b0;
         hold_vld_ff  <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         n_ff         <= n_in;
         p1_vld_ff    <= p1_vld_in;
         hold_vld_ff  <= hold_vld_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff        <= func_in;
      handle_ff      <= handle_in;
      delay_ff       <= delay_in;
      period_ff      <= period_in;
      p1_slot_ff     <= p1_slot_in;
      hold_slot_ff   <= hold_slot_in;
      hold_handle_ff <= hold_handle_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_run_handle  = rsp_handle_ff;
   assign rsp_last        = rsp_last_ff;

   // a new request never finds sweep work left over
   `PTS_ASSERT_NOW(a_idle_clean, clock, reset, req_valid && req_ready, !p1_vld_ff && !hold_vld_ff)
   // held runs only exist while a dispatch is being finished
   `PTS_ASSERT_NOW(a_hold_scope, clock, reset, hold_vld_ff, (state_ff == S_SWEEP) || (state_ff == S_FLUSH))
   // the flush always delivers the closing run
   `PTS_ASSERT_NEXT(a_flush_last, clock, reset, (state_ff == S_FLUSH) && out_free, rsp_valid && rsp_last && (rsp_result_kind == KIND_RUN))

endmodule

`default_nettype wire

/* tb/periodic_task_slot_table_test.sv */
`timescale 1ns / 100ps

module periodic_task_slot_table_test;
   import pts_pkg::*;

   localparam int SLOT_COUNT    = 16;
   localparam int TIME_BITS     = 16;
   localparam int RANDOM_ITEMS  = 143;
   localparam int LONG_HOLD     = 300;
   localparam int DIRECTED_ROWS = 27;

   typedef struct packed {
      func_type    func;
      logic [7:0]  handle;
      logic [15:0] delay;
      logic [15:0] period;
      logic [3:0]  slot;
   } slot_request_type;

   typedef struct packed {
      logic       kind;
      logic       status;
      logic [3:0] slot;
      logic [7:0] handle;
      logic       last;
   } slot_response_type;

   typedef struct packed {
      slot_request_type  req;
      logic              typed;
      slot_response_type ack;
      logic              hold;
   } directed_step_type;

   localparam slot_response_type NOT_TYPED = '0;
   localparam slot_response_type REJECTED  =
      '{KIND_ADD_ACK, STATUS_REJECT, 4'd0, 8'h00, 1'b1};

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func        = '0;
   logic [7:0]  req_task_handle = '0;
   logic [15:0] req_first_delay = '0;
   logic [15:0] req_run_period  = '0;
   logic [3:0]  req_slot_number = '0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_result_kind;
   logic        rsp_status;
   logic [3:0]  rsp_slot_index;
   logic [7:0]  rsp_run_handle;
   logic        rsp_last;

   // scheduler state as the block should hold it
   bit [7:0]  slot_owner   [SLOT_COUNT];
   bit [15:0] ticks_left   [SLOT_COUNT];
   bit [15:0] reload_ticks [SLOT_COUNT];
   bit [7:0]  runs_owed    [SLOT_COUNT];

   slot_response_type responses_due[$];
   int                mismatch_count = 0;
   int                accepted_count = 0;
   bit                steady         = 1'b0;
   bit                hold_request   = 1'b0;

   directed_step_type directed_steps [DIRECTED_ROWS];

   periodic_task_slot_table #(
      .SLOT_COUNT(SLOT_COUNT),
      .TIME_BITS (TIME_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_task_handle(req_task_handle),
      .req_first_delay(req_first_delay),
      .req_run_period (req_run_period),
      .req_slot_number(req_slot_number),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_run_handle (rsp_run_handle),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   function automatic slot_response_type placed_ack(input int slot);
      return slot_response_type'{KIND_ADD_ACK, STATUS_OK, 4'(slot), 8'h00, 1'b1};
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return int'($urandom_range(1, 3));
      return int'($urandom_range(6, 40));
   endfunction

   function automatic logic [7:0] pick_handle();
      if ($urandom_range(0, 15) == 0)
         return 8'h00;
      return 8'($urandom_range(1, 255));
   endfunction

   // mostly short delays so that tasks actually fall due
   function automatic logic [15:0] pick_ticks();
      if ($urandom_range(0, 99) < 85)
         return 16'($urandom_range(0, 4));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic void vacate(input int s);
      slot_owner[s]   = '0;
      ticks_left[s]   = '0;
      reload_ticks[s] = '0;
      runs_owed[s]    = '0;
   endfunction

   function automatic void advance_schedule(input slot_request_type r);
      int                placed_at;
      int                runs;
      slot_response_type tail;
      placed_at = -1;
      runs      = 0;
      case (r.func)
         FUNC_TICK: begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
               if (slot_owner[s] != 0) begin
                  if (ticks_left[s] == 0) begin
                     if (runs_owed[s] != PEND_MAX)
                        runs_owed[s]++;
                     ticks_left[s] = reload_ticks[s];
                  end else begin
                     ticks_left[s]--;
                  end
               end
            end
         end
         FUNC_ADD: begin
            if (r.handle != 0) begin
               for (int s = 0; s < SLOT_COUNT && placed_at < 0; s++)
                  if (slot_owner[s] == 0)
                     placed_at = s;
            end
            if (placed_at >= 0) begin
               slot_owner[placed_at]   = r.handle;
               ticks_left[placed_at]   = r.delay;
               reload_ticks[placed_at] = r.period;
               runs_owed[placed_at]    = '0;
               responses_due.push_back(placed_ack(placed_at));
            end else begin
               responses_due.push_back(REJECTED);
            end
         end
         FUNC_DELETE: begin
            // a 4-bit slot number always lies inside a 16-slot table
            vacate(int'(r.slot));
         end
         default: begin
            for (int s = 0; s < SLOT_COUNT && runs < MAX_RESULTS; s++) begin
               if (runs_owed[s] != 0) begin
                  responses_due.push_back(slot_response_type'{KIND_RUN, STATUS_OK, 4'(s),
                                                              slot_owner[s], 1'b0});
                  runs++;
                  runs_owed[s]--;
                  // one-shot task leaves the table, any further runs with it
                  if (reload_ticks[s] == 0)
                     vacate(s);
               end
            end
            if (runs > 0) begin
               tail      = responses_due.pop_back();
               tail.last = 1'b1;
               responses_due.push_back(tail);
            end
         end
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer_request(input slot_request_type r, input bit use_typed = 1'b0,
                                input slot_response_type typed_ack = NOT_TYPED,
                                input bit hold_after = 1'b0);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= r.func;
      req_task_handle <= r.handle;
      req_first_delay <= r.delay;
      req_run_period  <= r.period;
      req_slot_number <= r.slot;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      accepted_count++;
      advance_schedule(r);
      if (use_typed) begin
         void'(responses_due.pop_back());
         responses_due.push_back(typed_ack);
      end
      if (hold_after)
         hold_request = 1'b1;
      @(negedge clock);
   endtask

   function automatic slot_request_type random_request(input func_type f);
      return slot_request_type'{f, 8'($urandom), 16'($urandom), 16'($urandom),
                                4'($urandom)};
   endfunction

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      slot_response_type seen;
      slot_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_result_kind, rsp_status, rsp_slot_index, rsp_run_handle, rsp_last};
         if (responses_due.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, kind %0b slot %0d handle 0x%02h",
                                      seen.kind, seen.slot, seen.handle));
         end else begin
            want = responses_due.pop_front();
            if (seen.kind !== want.kind)
               report_mismatch($sformatf("rsp_result_kind %0b, expected %0b",
                                         seen.kind, want.kind));
            if (seen.status !== want.status)
               report_mismatch($sformatf("rsp_status %0b, expected %0b",
                                         seen.status, want.status));
            if (seen.slot !== want.slot)
               report_mismatch($sformatf("rsp_slot_index %0d, expected %0d",
                                         seen.slot, want.slot));
            if (seen.handle !== want.handle)
               report_mismatch($sformatf("rsp_run_handle 0x%02h, expected 0x%02h",
                                         seen.handle, want.handle));
            if (seen.last !== want.last)
               report_mismatch($sformatf("rsp_last %0b, expected %0b",
                                         seen.last, want.last));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("periodic_task_slot_table: mismatch");
      $finish;
   end

   initial begin
      int random_goal;
      int target;
      int tries;
      int drain_wait;

      directed_steps = '{
         '{'{FUNC_ADD,      8'h01, 16'h0000, 16'h0000, 4'd0}, 1'b1, placed_ack(0), 1'b0},
         '{'{FUNC_ADD,      8'h00, 16'hFFFF, 16'hFFFF, 4'd0}, 1'b1, REJECTED,      1'b0},
         '{'{FUNC_ADD,      8'hFF, 16'hFFFF, 16'hFFFF, 4'd0}, 1'b1, placed_ack(1), 1'b0},
         '{'{FUNC_ADD,      8'h80, 16'h0000, 16'h0001, 4'd0}, 1'b1, placed_ack(2), 1'b0},
         '{'{FUNC_TICK,     8'h00, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_TICK,     8'hFF, 16'hFFFF, 16'hFFFF, 4'd15}, 1'b0, NOT_TYPED,    1'b0},
         '{'{FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_DELETE,   8'h00, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_DELETE,   8'h00, 16'h0000, 16'h0000, 4'd1}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h31, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h32, 16'h0000, 16'h0001, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h33, 16'h0000, 16'h0002, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h34, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h35, 16'h0000, 16'h0003, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h36, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h37, 16'h0000, 16'h0001, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h38, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h39, 16'h0000, 16'h0002, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h3A, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h3B, 16'h0000, 16'h0005, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h3C, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h3D, 16'h0000, 16'h0001, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h3E, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h3F, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         '{'{FUNC_ADD,      8'h40, 16'h0000, 16'h0000, 4'd0}, 1'b1, REJECTED,      1'b0},
         '{'{FUNC_TICK,     8'h00, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b0},
         // every slot falls due: a full dispatch while the receiver holds off
         '{'{FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0}, 1'b0, NOT_TYPED,     1'b1}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         offer_request(directed_steps[i].req, directed_steps[i].typed,
                       directed_steps[i].ack, directed_steps[i].hold);

      random_goal = accepted_count + RANDOM_ITEMS;
      while (accepted_count < random_goal) begin
         steady = (accepted_count > random_goal - 110) && (accepted_count < random_goal - 70);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               repeat ($urandom_range(1, 4))
                  offer_request(slot_request_type'{FUNC_ADD, pick_handle(), pick_ticks(),
                                                   pick_ticks(), 4'($urandom)});
            end
            3, 4, 5: begin
               repeat ($urandom_range(1, 6))
                  offer_request(random_request(FUNC_TICK));
               offer_request(random_request(FUNC_DISPATCH));
            end
            6, 7: begin
               // lean towards occupied slots, empty ones still turn up
               target = $urandom_range(0, SLOT_COUNT - 1);
               for (tries = 0; tries < 3 && slot_owner[target] == 0; tries++)
                  target = $urandom_range(0, SLOT_COUNT - 1);
               offer_request(slot_request_type'{FUNC_DELETE, 8'($urandom), 16'($urandom),
                                                16'($urandom), 4'(target)});
            end
            8: offer_request(random_request(FUNC_DISPATCH));
            default: offer_request(random_request(func_type'($urandom_range(0, 3))));
         endcase
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      drain_wait = 0;
      while (responses_due.size() != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (4 * SLOT_COUNT) @(posedge clock);
      if (responses_due.size() != 0)
         report_mismatch($sformatf("%0d expected transactions never arrived",
                                   responses_due.size()));

      if (mismatch_count == 0)
         $display("periodic_task_slot_table: match");
      else
         $display("periodic_task_slot_table: mismatch");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/pts_pkg.sv
hdl/pts_ram.sv
hdl/pts_slot_upd.sv
hdl/periodic_task_slot_table.sv
tb/periodic_task_slot_table_test.sv
